[design/sh3_pkg.sv]
// Shared types, constants and helper functions of the 3x3 sharpening filter.
package sh3_pkg;

   // Default frame limits of the line stores.
   localparam int unsigned DEFAULT_MAX_WIDTH  = 1024;
   localparam int unsigned DEFAULT_MAX_HEIGHT = 1024;

   // Configuration port.
   localparam int unsigned CSR_INDEX_WIDTH = 4;
   localparam int unsigned CFG_DATA_WIDTH  = 11;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_IMAGE_WIDTH  = CSR_INDEX_WIDTH'(0);
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_IMAGE_HEIGHT = CSR_INDEX_WIDTH'(1);
   localparam int unsigned DIM_RESET = 256;
   localparam int unsigned DIM_MIN   = 3;

   // Result field widths.
   localparam int unsigned POS_WIDTH = 10;
   localparam int unsigned PIX_WIDTH = 8;

   // Queue between the front and back parts.
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_AW    = 2;
   localparam int unsigned QUEUE_CW    = QUEUE_AW + 1;

   // Which results one input pixel causes, in the order they are given.
   typedef struct packed {
      logic left;    // first column of the row above
      logic inner;   // filtered pixel one column back in the row above
      logic right;   // last column of the row above
      logic bottom;  // the pixel itself on the last row
   } emit_flags_type;

   // One classified input pixel waiting to be expanded into results.
   typedef struct packed {
      emit_flags_type        flags;
      logic [POS_WIDTH-1:0]  row_up;
      logic [POS_WIDTH-1:0]  row_cur;
      logic [POS_WIDTH-1:0]  col_cur;
      logic [POS_WIDTH-1:0]  col_prev;
      logic [PIX_WIDTH-1:0]  mid;
      logic [PIX_WIDTH-1:0]  pix;
      logic [PIX_WIDTH-1:0]  filt;
   } item_type;

   // Effective frame dimension: below the minimum acts as the minimum, above the
   // maximum as the maximum.
   function automatic int unsigned clamp_dim(logic [CFG_DATA_WIDTH-1:0] raw,
                                             int unsigned max_dim);
      int unsigned v;
      begin
         v = 32'(raw);
         if (v < DIM_MIN) begin
            return DIM_MIN;
         end else if (v > max_dim) begin
            return max_dim;
         end
         return v;
      end
   endfunction

   // Kernel: 8*centre minus the four corners, quartered and clamped to 0..255.
   function automatic logic [PIX_WIDTH-1:0] sharpen(logic [PIX_WIDTH-1:0] centre,
                                                    logic [9:0] corners);
      logic signed [11:0] v;
      begin
         v = signed'({1'b0, centre, 3'b000}) - signed'({2'b00, corners});
         if (v < 0) begin
            return '0;
         end else if (v[10:2] > 9'd255) begin
            return 8'd255;
         end
         return v[9:2];
      end
   endfunction

endpackage

[design/sh3_front.sv]
// Front part: frame counters, line stores, window registers and kernel arithmetic.
module sh3_front #(
   parameter int unsigned MAX_WIDTH  = sh3_pkg::DEFAULT_MAX_WIDTH,
   parameter int unsigned MAX_HEIGHT = sh3_pkg::DEFAULT_MAX_HEIGHT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   in_valid,
   input  logic [sh3_pkg::PIX_WIDTH-1:0]          in_pixel,
   input  logic                                   cfg_valid,
   input  logic [sh3_pkg::CSR_INDEX_WIDTH-1:0]    cfg_index,
   input  logic [sh3_pkg::CFG_DATA_WIDTH-1:0]     cfg_data,
   output logic                                   busy,
   output logic                                   push,
   output sh3_pkg::item_type                      push_item
);
   import sh3_pkg::*;

   localparam int unsigned AW  = $clog2(MAX_WIDTH);
   localparam int unsigned DW  = $clog2(MAX_WIDTH + 1);
   localparam int unsigned RAW = $clog2(MAX_HEIGHT);
   localparam int unsigned RDW = $clog2(MAX_HEIGHT + 1);

   // Effective frame size and raster position of the next pixel.
   logic [DW-1:0]  eff_w_ff;
   logic [RDW-1:0] eff_h_ff;
   logic [AW-1:0]  col_ff, col_in;
   logic [RAW-1:0] row_ff, row_in;

   // Line stores.
   logic [PIX_WIDTH-1:0] line_one_up_ff [MAX_WIDTH];
   logic [PIX_WIDTH-1:0] line_two_up_ff [MAX_WIDTH];
   logic [PIX_WIDTH-1:0] rd_one_ff, rd_two_ff;

   // Pixel stage after the store read.
   logic                 s1_valid_ff;
   logic [PIX_WIDTH-1:0] s1_pix_ff;
   logic [AW-1:0]        s1_col_ff;
   logic                 s1_row_one_ff;
   emit_flags_type       s1_flags_ff;
   logic [POS_WIDTH-1:0] s1_row_up_ff, s1_row_cur_ff, s1_col_cur_ff, s1_col_prev_ff;

   // Window: columns c-1 (a) and c-2 (b) of the top and bottom rows, centre of c-1.
   logic [PIX_WIDTH-1:0] win_top_a_ff, win_mid_a_ff, win_bot_a_ff;
   logic [PIX_WIDTH-1:0] win_top_b_ff, win_bot_b_ff;

   logic           col_last, row_last, row_nz;
   logic           frame_restart;
   emit_flags_type flags_in;
   logic [9:0]     corners;
   logic [PIX_WIDTH-1:0] filt;

   // Position decoding of the pixel being accepted.
   always_comb begin
      col_last       = (DW'(col_ff) == eff_w_ff - DW'(1));
      row_last       = (RDW'(row_ff) == eff_h_ff - RDW'(1));
      row_nz         = (row_ff != '0);
      flags_in.left  = row_nz && (col_ff == '0);
      flags_in.inner = row_nz && (col_ff >= AW'(2));
      flags_in.right = row_nz && col_last;
      flags_in.bottom = row_last;
      // Only a write to a known register restarts the frame.
      frame_restart  = cfg_valid && (cfg_index inside {REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT});
      if (col_last) begin
         col_in = '0;
         row_in = row_last ? '0 : row_ff + RAW'(1);
      end else begin
         col_in = col_ff + AW'(1);
         row_in = row_ff;
      end
   end

   // Frame size registers and raster counters; a write to either frame register restarts the frame.
   always_ff @(posedge clock) begin
      if (reset) begin
         eff_w_ff <= DW'(clamp_dim(CFG_DATA_WIDTH'(DIM_RESET), MAX_WIDTH));
         eff_h_ff <= RDW'(clamp_dim(CFG_DATA_WIDTH'(DIM_RESET), MAX_HEIGHT));
         col_ff   <= '0;
         row_ff   <= '0;
      end else if (cfg_valid) begin
         if (cfg_index == REG_IMAGE_WIDTH) begin
            eff_w_ff <= DW'(clamp_dim(cfg_data, MAX_WIDTH));
            col_ff   <= '0;
            row_ff   <= '0;
         end else if (cfg_index == REG_IMAGE_HEIGHT) begin
            eff_h_ff <= RDW'(clamp_dim(cfg_data, MAX_HEIGHT));
            col_ff   <= '0;
            row_ff   <= '0;
         end
      end else if (in_valid) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Row above: read the old entry and store the new pixel in the same cycle.
   always_ff @(posedge clock) begin
      if (in_valid) begin
         rd_one_ff              <= line_one_up_ff[col_ff];
         line_one_up_ff[col_ff] <= in_pixel;
      end
   end

   // Two rows above: read on accept, written back in the next cycle with the row above.
   always_ff @(posedge clock) begin
      if (in_valid) begin
         rd_two_ff <= line_two_up_ff[col_ff];
      end
      if (s1_valid_ff) begin
         line_two_up_ff[s1_col_ff] <= rd_one_ff;
      end
   end

   // Stage register carrying the pixel and its classification.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
      end
      if (in_valid) begin
         s1_pix_ff      <= in_pixel;
         s1_col_ff      <= col_ff;
         s1_row_one_ff  <= (row_ff == RAW'(1));
         s1_flags_ff    <= flags_in;
         s1_row_up_ff   <= POS_WIDTH'(row_ff) - POS_WIDTH'(1);
         s1_row_cur_ff  <= POS_WIDTH'(row_ff);
         s1_col_cur_ff  <= POS_WIDTH'(col_ff);
         s1_col_prev_ff <= POS_WIDTH'(col_ff) - POS_WIDTH'(1);
      end
   end

   // Window shift as each pixel leaves the stage.
   always_ff @(posedge clock) begin
      if (reset || frame_restart) begin
         win_top_a_ff <= '0;
         win_mid_a_ff <= '0;
         win_bot_a_ff <= '0;
         win_top_b_ff <= '0;
         win_bot_b_ff <= '0;
      end else if (s1_valid_ff) begin
         win_top_b_ff <= win_top_a_ff;
         win_bot_b_ff <= win_bot_a_ff;
         win_top_a_ff <= rd_two_ff;
         win_mid_a_ff <= rd_one_ff;
         win_bot_a_ff <= s1_pix_ff;
      end
   end

   // Kernel on the window; while the second row arrives, the centre is copied as a border pixel.
   always_comb begin
      corners = 10'(win_top_b_ff) + 10'(win_bot_b_ff) + 10'(rd_two_ff) + 10'(s1_pix_ff);
      filt    = s1_row_one_ff ? win_mid_a_ff : sharpen(win_mid_a_ff, corners);
   end

   // Hand the classified pixel to the queue when it causes any result.
   always_comb begin
      busy               = s1_valid_ff;
      push               = s1_valid_ff && (s1_flags_ff != '0);
      push_item.flags    = s1_flags_ff;
      push_item.row_up   = s1_row_up_ff;
      push_item.row_cur  = s1_row_cur_ff;
      push_item.col_cur  = s1_col_cur_ff;
      push_item.col_prev = s1_col_prev_ff;
      push_item.mid      = rd_one_ff;
      push_item.pix      = s1_pix_ff;
      push_item.filt     = filt;
   end

endmodule

[design/sh3_queue.sv]
// Short first-in first-out queue of classified pixels between front and back.
module sh3_queue (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push,
   input  sh3_pkg::item_type               push_item,
   input  logic                            pop,
   output logic                            not_empty,
   output sh3_pkg::item_type               head,
   output logic [sh3_pkg::QUEUE_CW-1:0]    count
);
   import sh3_pkg::*;

   item_type              entries_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_CW-1:0]   count_ff, count_in;
   logic                  do_pop;

   // Occupancy bookkeeping.
   always_comb begin
      do_pop   = pop && (count_ff != '0);
      count_in = count_ff + QUEUE_CW'(push) - QUEUE_CW'(do_pop);
   end

   // Pointers and count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QUEUE_AW'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + QUEUE_AW'(1);
         end
         count_ff <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head      = entries_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign count     = count_ff;

endmodule

[design/sh3_back.sv]
// Back part: expands each queued pixel into its results, one per transaction.
module sh3_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            q_valid,
   input  sh3_pkg::item_type               q_head,
   output logic                            q_pop,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output logic [sh3_pkg::POS_WIDTH-1:0]   rsp_out_row,
   output logic [sh3_pkg::POS_WIDTH-1:0]   rsp_out_col,
   output logic [sh3_pkg::PIX_WIDTH-1:0]   rsp_pixel_out,
   output logic                            rsp_run_last
);
   import sh3_pkg::*;

   item_type       cur_ff;
   logic           cur_valid_ff;
   emit_flags_type rest;
   logic           taken, load;

   // Pick the earliest pending result and work out which remain after it.
   always_comb begin
      rest = cur_ff.flags;
      if (cur_ff.flags.left) begin
         rest.left     = 1'b0;
         rsp_out_row   = cur_ff.row_up;
         rsp_out_col   = '0;
         rsp_pixel_out = cur_ff.mid;
      end else if (cur_ff.flags.inner) begin
         rest.inner    = 1'b0;
         rsp_out_row   = cur_ff.row_up;
         rsp_out_col   = cur_ff.col_prev;
         rsp_pixel_out = cur_ff.filt;
      end else if (cur_ff.flags.right) begin
         rest.right    = 1'b0;
         rsp_out_row   = cur_ff.row_up;
         rsp_out_col   = cur_ff.col_cur;
         rsp_pixel_out = cur_ff.mid;
      end else begin
         rest.bottom   = 1'b0;
         rsp_out_row   = cur_ff.row_cur;
         rsp_out_col   = cur_ff.col_cur;
         rsp_pixel_out = cur_ff.pix;
      end
      rsp_run_last = (rest == '0);
      rsp_empty    = !cur_valid_ff;
      taken        = rsp_pop && cur_valid_ff;
      load         = q_valid && (!cur_valid_ff || (taken && rsp_run_last));
      q_pop        = load;
   end

   // Current pixel register, refilled from the queue as its last result goes.
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
      end else if (load) begin
         cur_valid_ff <= 1'b1;
      end else if (taken && rsp_run_last) begin
         cur_valid_ff <= 1'b0;
      end
      if (load) begin
         cur_ff <= q_head;
      end else if (taken) begin
         cur_ff.flags <= rest;
      end
   end

endmodule

[design/sharpen_3x3_filter_core.sv]
// Top level of the streaming 3x3 sharpening filter for 8-bit grey frames.
//
// Pixels enter in raster order, one per clock while req_full is low. Each
// interior pixel of the row above is sharpened (centre 8, corners -1, divided
// by 4, truncated and clamped to 0..255); border pixels are copied. Results come
// out tagged with row and column, one per clock while rsp_empty is low and
// rsp_pop is high: a pixel causes no result on the first row, one on most rows,
// and up to three at the start or end of a row and on the last row. rsp_run_last
// marks the last result of each input pixel. A pixel passes the front stage
// register, the queue and the back part's current pixel register; the two line
// stores are read in the accepting cycle and the kernel is worked out in the
// next. A four-entry queue between the classifying front part and the result
// part lets either side stall on its own. Line stores need no clearing after
// reset. Writing either frame register restarts the frame at row 0, column 0 and
// should only be done while no results are outstanding; csr_ready is always high.
module sharpen_3x3_filter_core #(
   parameter int unsigned MAX_WIDTH  = sh3_pkg::DEFAULT_MAX_WIDTH,
   parameter int unsigned MAX_HEIGHT = sh3_pkg::DEFAULT_MAX_HEIGHT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_push,
   output logic                                  req_full,
   input  logic [sh3_pkg::PIX_WIDTH-1:0]         req_pixel_in,
   output logic                                  rsp_empty,
   input  logic                                  rsp_pop,
   output logic [sh3_pkg::POS_WIDTH-1:0]         rsp_out_row,
   output logic [sh3_pkg::POS_WIDTH-1:0]         rsp_out_col,
   output logic [sh3_pkg::PIX_WIDTH-1:0]         rsp_pixel_out,
   output logic                                  rsp_run_last,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [sh3_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [sh3_pkg::CFG_DATA_WIDTH-1:0]    csr_data
);
   import sh3_pkg::*;

   logic                accept;
   logic                front_busy, front_push;
   item_type            front_item, q_head;
   logic                q_not_empty, q_pop;
   logic [QUEUE_CW-1:0] q_count;
   logic [QUEUE_CW:0]   level;

   // Space check counts the pixel still in the front stage.
   always_comb begin
      level     = {1'b0, q_count} + (QUEUE_CW + 1)'(front_busy);
      req_full  = (level >= (QUEUE_CW + 1)'(QUEUE_DEPTH));
      accept    = req_push && !req_full;
      csr_ready = 1'b1;
   end

   sh3_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_pixel  (req_pixel_in),
      .cfg_valid (csr_valid),
      .cfg_index (csr_index),
      .cfg_data  (csr_data),
      .busy      (front_busy),
      .push      (front_push),
      .push_item (front_item)
   );

   sh3_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_push),
      .push_item (front_item),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head      (q_head),
      .count     (q_count)
   );

   sh3_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_not_empty),
      .q_head        (q_head),
      .q_pop         (q_pop),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_out_row   (rsp_out_row),
      .rsp_out_col   (rsp_out_col),
      .rsp_pixel_out (rsp_pixel_out),
      .rsp_run_last  (rsp_run_last)
   );

endmodule

[tb/sv/tb_sharpen_3x3_filter_core.sv]
// Self-checking testbench of the streaming 3x3 sharpening filter core.
`timescale 1ns / 100ps

module tb_sharpen_3x3_filter_core;
   import sh3_pkg::*;

   localparam int unsigned MAX_W = DEFAULT_MAX_WIDTH;
   localparam int unsigned MAX_H = DEFAULT_MAX_HEIGHT;
   localparam int unsigned RANDOM_ITEMS = 30;
   localparam int unsigned STEADY_ITEMS = 24;
   localparam int unsigned QUIET_LIMIT = 3000;
   localparam int unsigned SETTLE_CYCLES = 16;
   localparam int unsigned HOLD_CYCLES = 300;
   localparam int unsigned HOLD_AFTER = 24;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_BEYOND_LAST = REG_IMAGE_HEIGHT + 1'b1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_INDEX_TOP = '1;

   // One output transaction: position, value and the end-of-run marker.
   typedef struct packed {
      logic [POS_WIDTH-1:0] row;
      logic [POS_WIDTH-1:0] col;
      logic [PIX_WIDTH-1:0] pix;
      logic                 run_last;
   } filtered_px_type;

   // Tracks the filter state and the outputs still owed by the block.
   class sharpen_tracker;
      logic [CFG_DATA_WIDTH-1:0] width_raw;
      logic [CFG_DATA_WIDTH-1:0] height_raw;
      bit [PIX_WIDTH-1:0]        one_up[MAX_W];
      bit [PIX_WIDTH-1:0]        two_up[MAX_W];
      bit [PIX_WIDTH-1:0]        win[6];
      int unsigned               row_pos;
      int unsigned               col_pos;
      filtered_px_type           owed[$];
      int unsigned               errors;
      int unsigned               checked;

      function new();
         width_raw = DIM_RESET;
         height_raw = DIM_RESET;
         errors = 0;
         checked = 0;
         restart();
      endfunction

      function void restart();
         row_pos = 0;
         col_pos = 0;
         foreach (win[i]) win[i] = '0;
      endfunction

      function int unsigned eff_dim(logic [CFG_DATA_WIDTH-1:0] raw, int unsigned top_dim);
         if (raw < DIM_MIN) return DIM_MIN;
         if (raw > top_dim) return top_dim;
         return raw;
      endfunction

      function int unsigned pending();
         return owed.size();
      endfunction

      // A register write restarts the frame; unknown indexes are ignored.
      function void note_config(logic [CSR_INDEX_WIDTH-1:0] idx,
                                logic [CFG_DATA_WIDTH-1:0] val);
         if (idx == REG_IMAGE_WIDTH) begin
            width_raw = val;
            restart();
         end else if (idx == REG_IMAGE_HEIGHT) begin
            height_raw = val;
            restart();
         end
      endfunction

      function void owe(int unsigned r, int unsigned c, logic [PIX_WIDTH-1:0] v);
         filtered_px_type item;
         item.row = r[POS_WIDTH-1:0];
         item.col = c[POS_WIDTH-1:0];
         item.pix = v;
         item.run_last = 1'b0;
         owed.push_back(item);
      endfunction

      // Eight times the centre less the corners, quartered and clamped.
      function logic [PIX_WIDTH-1:0] sharpened(logic [PIX_WIDTH-1:0] centre,
                                               int unsigned corners);
         int v;
         v = 8 * int'(centre) - int'(corners);
         if (v < 0) return '0;
         v = v >>> 2;
         if (v > 255) return 8'd255;
         return v[PIX_WIDTH-1:0];
      endfunction

      // Works out the outputs caused by one accepted pixel and advances the state.
      function void note_pixel(logic [PIX_WIDTH-1:0] p);
         int unsigned w, h, r, c, n, corners;
         logic [PIX_WIDTH-1:0] top, mid;
         filtered_px_type tail;
         w = eff_dim(width_raw, MAX_W);
         h = eff_dim(height_raw, MAX_H);
         r = (row_pos >= h) ? 0 : row_pos;
         c = (col_pos >= w) ? 0 : col_pos;
         n = 0;
         top = two_up[c];
         mid = one_up[c];
         two_up[c] = mid;
         one_up[c] = p;

         // The row above is given out while this row streams in.
         if (r >= 1) begin
            if (c == 0) begin
               owe(r - 1, 0, mid);
               n++;
            end
            if (c >= 2) begin
               if (r == 1) begin
                  owe(r - 1, c - 1, win[1]);
               end else begin
                  corners = int'(win[3]) + int'(win[5]) + int'(top) + int'(p);
                  owe(r - 1, c - 1, sharpened(win[1], corners));
               end
               n++;
            end
            if (c == w - 1) begin
               owe(r - 1, c, mid);
               n++;
            end
         end
         // The last row is copied as it arrives.
         if (r == h - 1) begin
            owe(r, c, p);
            n++;
         end
         if (n > 0) begin
            tail = owed.pop_back();
            tail.run_last = 1'b1;
            owed.push_back(tail);
         end

         win[3] = win[0];
         win[4] = win[1];
         win[5] = win[2];
         win[0] = top;
         win[1] = mid;
         win[2] = p;
         if (c + 1 >= w) begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : r + 1;
         end else begin
            col_pos = c + 1;
            row_pos = r;
         end
      endfunction

      task report(string what, int got, int want);
         errors++;
         if (errors <= 20) begin
            $display("%0t: output %0d, %s: got %0d, expected %0d",
                     $time, checked, what, got, want);
         end
      endtask

      // Compares one accepted output with the oldest one owed.
      task check_result(filtered_px_type got);
         filtered_px_type want;
         checked++;
         if (owed.size() == 0) begin
            report("output with nothing owed, row", got.row, -1);
         end else begin
            want = owed.pop_front();
            if (got.row != want.row) report("row", got.row, want.row);
            if (got.col != want.col) report("column", got.col, want.col);
            if (got.pix != want.pix) report("pixel", got.pix, want.pix);
            if (got.run_last != want.run_last) report("run_last", got.run_last, want.run_last);
         end
      endtask
   endclass

   logic                       clock;
   logic                       reset = 1'b1;
   logic                       req_push = 1'b0;
   logic                       req_full;
   logic [PIX_WIDTH-1:0]       req_pixel_in = '0;
   logic                       rsp_empty;
   logic                       rsp_pop = 1'b0;
   logic [POS_WIDTH-1:0]       rsp_out_row;
   logic [POS_WIDTH-1:0]       rsp_out_col;
   logic [PIX_WIDTH-1:0]       rsp_pixel_out;
   logic                       rsp_run_last;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CFG_DATA_WIDTH-1:0]  csr_data = '0;

   bit             steady_flow = 1'b0;
   sharpen_tracker sb = new();

   sharpen_3x3_filter_core dut (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_pixel_in  (req_pixel_in),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_out_row   (rsp_out_row),
      .rsp_out_col   (rsp_out_col),
      .rsp_pixel_out (rsp_pixel_out),
      .rsp_run_last  (rsp_run_last),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Mostly uniform pixels, with a share of full black and full white.
   function automatic logic [PIX_WIDTH-1:0] pick_pixel();
      if ($urandom_range(4) == 0) return ($urandom_range(1) == 1) ? 8'hFF : 8'h00;
      return PIX_WIDTH'($urandom_range(255));
   endfunction

   // Offers one pixel, with random idle cycles before it, until it is taken.
   task automatic send_pixel(input logic [PIX_WIDTH-1:0] pix);
      while (!steady_flow && $urandom_range(99) < 30) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_pixel_in <= pix;
      do @(posedge clock); while (req_full);
      sb.note_pixel(pix);
   endtask

   // One register write transaction; the caller lowers csr_valid afterwards.
   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CFG_DATA_WIDTH-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      sb.note_config(idx, val);
   endtask

   task automatic set_frame(input logic [CFG_DATA_WIDTH-1:0] w_raw,
                            input logic [CFG_DATA_WIDTH-1:0] h_raw, input bit with_stray);
      write_reg(REG_IMAGE_WIDTH, w_raw);
      write_reg(REG_IMAGE_HEIGHT, h_raw);
      if (with_stray) begin
         write_reg(CSR_INDEX_WIDTH'($urandom_range(REG_INDEX_TOP, REG_BEYOND_LAST)),
                   CFG_DATA_WIDTH'($urandom));
      end
      csr_valid <= 1'b0;
   endtask

   // Stops offering, waits for every owed output and lets the pipeline drain.
   task automatic settle();
      req_push <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Output side: random pops, one long hold-off, and a check per transaction.
   initial begin : output_side
      int unsigned hold;
      bit          held_once;
      filtered_px_type got;
      hold = 0;
      held_once = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_pop && !rsp_empty) begin
            got.row = rsp_out_row;
            got.col = rsp_out_col;
            got.pix = rsp_pixel_out;
            got.run_last = rsp_run_last;
            sb.check_result(got);
         end
         if (!held_once && steady_flow && sb.checked >= HOLD_AFTER) begin
            held_once = 1'b1;
            hold = HOLD_CYCLES;
         end
         if (hold > 0) begin
            hold--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= steady_flow || ($urandom_range(99) >= 30);
         end
      end
   end

   // Ends the run when no transaction of any kind has happened for too long.
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty) || (csr_valid && csr_ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("sharpen_3x3_filter_core: mismatch");
      $finish;
   end

   // Stimulus: reset values, directed frames, a steady tall frame, then random frames.
   initial begin : stimulus
      logic [CFG_DATA_WIDTH-1:0] w_raw, h_raw;
      int unsigned w, h, count, random_items;
      bit corner;
      random_items = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Reset frame size: finish the first row and start the second.
      repeat (DIM_RESET + 2) send_pixel(pick_pixel());
      settle();

      // A write to an unknown index must not restart the frame.
      write_reg(REG_INDEX_TOP, '1);
      csr_valid <= 1'b0;
      repeat (4) send_pixel(pick_pixel());
      settle();

      // Dimensions below the minimum act as 3x3. The first frame clamps high
      // (bright centre, dark corners), the second low after the frame wraps.
      set_frame('0, 11'd2, 1'b0);
      for (int f = 0; f < 2; f++) begin
         for (int k = 0; k < 9; k++) begin
            corner = (k % 3 != 1) && (k / 3 != 1);
            send_pixel((corner ^ f[0]) ? 8'h00 : 8'hFF);
         end
      end
      settle();

      // Narrowest rows of a frame taller than the maximum, with no idling; the
      // output side holds off for a while in here so that the block fills up.
      steady_flow = 1'b1;
      set_frame(11'd3, '1, 1'b0);
      repeat (STEADY_ITEMS) send_pixel(pick_pixel());
      settle();
      steady_flow = 1'b0;

      // Random small frames, whole or cut short.
      while (random_items < RANDOM_ITEMS) begin
         w_raw = ($urandom_range(9) == 0) ? CFG_DATA_WIDTH'($urandom_range(2))
                                          : CFG_DATA_WIDTH'($urandom_range(9, 3));
         case ($urandom_range(9))
            0: h_raw = CFG_DATA_WIDTH'($urandom_range(2));
            1: h_raw = CFG_DATA_WIDTH'($urandom_range(2047, MAX_H + 1));
            default: h_raw = CFG_DATA_WIDTH'($urandom_range(6, 3));
         endcase
         set_frame(w_raw, h_raw, $urandom_range(4) == 0);
         w = sb.eff_dim(w_raw, MAX_W);
         h = sb.eff_dim(h_raw, MAX_H);
         if (h > 8 || $urandom_range(3) == 0) begin
            count = $urandom_range(w * 6, 1);
         end else begin
            count = w * h * $urandom_range(2, 1);
         end
         if (count > RANDOM_ITEMS - random_items) begin
            count = RANDOM_ITEMS - random_items;
         end
         repeat (count) send_pixel(pick_pixel());
         random_items += count;
         settle();
      end

      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("sharpen_3x3_filter_core: match");
      end else begin
         $display("sharpen_3x3_filter_core: mismatch");
      end
      $finish;
   end

endmodule
